// File: hw/rtl/crs_pkg.sv
// Shared types and constants for the clip rectangle stack.
// Holds the request codes, rectangle and entry structs, and cell shift control.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

	// Request codes carried in the slave-side tuser
	typedef enum logic [2:0] {
		REQ_PUSH     = 3'd0,
		REQ_PUSH_RND = 3'd1,
		REQ_POP      = 3'd2,
		REQ_CLEAR    = 3'd3,
		REQ_QUERY    = 3'd4
	} req_t;

	localparam int CntOutW = 5;

	// Clip reported while the stack is empty
	localparam logic [19:0] DefaultExtent = 20'd1000000;

	// Rectangle in integer pixels: x, y signed, w, h unsigned
	typedef struct packed {
		logic [20:0] x;
		logic [20:0] y;
		logic [19:0] w;
		logic [19:0] h;
	} rect_t;

	// One stack entry
	typedef struct packed {
		rect_t rect;
		logic  rounded;
	} entry_t;

	// Shift command broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} shift_t;

	// Visibility results against the current clip
	typedef struct packed {
		rect_t       clip;
		logic [21:0] scissor_y;
		logic        is_clipped;
		logic        fully_visible;
	} check_t;

endpackage

`default_nettype wire

// File: hw/rtl/clip_rect_stack.sv
// Clip rectangle stack: a chain of cells with the top entry in cell 0.
// A request passes stage 1, stage 2 and the output register before its result beat is valid.
// Throughput: one request per cycle unless m_tready stalls; the top entry sits in a
// fixed cell, so intersection and visibility check each take one pipeline stage.
// Reset: asynchronous, clears depth, rounded count, viewport height and all valids;
// cell contents are left as they are until pushed.
`timescale 1ns / 1ps
`default_nettype none

module clip_rect_stack
	import crs_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [15:0]  cfg_wr_data,  // viewport_height
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [87:0]  s_tdata,      // rect_x, rect_y, rect_w, rect_h, zero pad
	input  wire logic [2:0]   s_tuser,      // req_type
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// clip_x, clip_y, clip_w, clip_h, scissor_y, is_clipped, fully_visible,
	// depth, rounded_count, overflow, zero pad
	output logic [143:0]      m_tdata
);

	localparam int CntW = $clog2(STACK_DEPTH + 1);
	localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);

	logic [15:0]     vh_q;
	logic [CntW-1:0] cnt_q, rnd_q;
	logic [CntW-1:0] cnt_nxt, rnd_nxt;

	logic            valid_s1;
	req_t            req_s1;
	rect_t           rect_s1;

	logic            valid_s2;
	rect_t           rect_s2;
	logic [CntW-1:0] cnt_s2, rnd_s2;
	logic            drop_s2;

	logic            out_valid_q;
	check_t          out_chk_q;
	logic [CntOutW-1:0] out_cnt_q, out_rnd_q;
	logic            out_drop_q;

	logic            out_free, s2_adv, s2_free, s1_adv;
	logic            do_push, do_pop, dropped;
	shift_t          shift;
	rect_t           new_rect;
	entry_t          new_entry;
	entry_t          cells [STACK_DEPTH];
	check_t          chk;
	logic [CntW+CntOutW-1:0] cnt_ext, rnd_ext;

	// Stage advance: each stage moves when the one after it has room
	assign out_free = !out_valid_q || m_tready;
	assign s2_adv   = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || s2_adv;
	assign s1_adv   = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s1_adv;

	// Viewport height register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vh_q <= '0;
		end else if (cfg_wr_en) begin
			vh_q <= cfg_wr_data;
		end
	end

	// Stage 1: hold the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1    <= req_t'(s_tuser);
			rect_s1.x <= s_tdata[20:0];
			rect_s1.y <= s_tdata[41:21];
			rect_s1.w <= s_tdata[61:42];
			rect_s1.h <= s_tdata[81:62];
		end
	end

	// Work out the stack operation and the new counts
	always_comb begin
		do_push = 1'b0;
		do_pop  = 1'b0;
		dropped = 1'b0;
		cnt_nxt = cnt_q;
		rnd_nxt = rnd_q;
		unique case (req_s1)
			REQ_PUSH, REQ_PUSH_RND: begin
				if (cnt_q == CntFull) begin
					dropped = 1'b1;
				end else begin
					do_push = 1'b1;
					cnt_nxt = cnt_q + 1'b1;
					if (req_s1 == REQ_PUSH_RND) begin
						rnd_nxt = rnd_q + 1'b1;
					end
				end
			end
			REQ_POP: begin
				if (cnt_q != '0) begin
					do_pop  = 1'b1;
					cnt_nxt = cnt_q - 1'b1;
					if (cells[0].rounded && rnd_q != '0) begin
						rnd_nxt = rnd_q - 1'b1;
					end
				end
			end
			REQ_CLEAR: begin
				cnt_nxt = '0;
				rnd_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	crs_isect u_isect (
		.top         (cells[0].rect),
		.stack_empty (cnt_q == '0),
		.rect        (rect_s1),
		.result      (new_rect)
	);

	assign new_entry.rect    = new_rect;
	assign new_entry.rounded = (req_s1 == REQ_PUSH_RND);
	assign shift.push        = s1_adv && do_push;
	assign shift.pop         = s1_adv && do_pop;

	// Chain of cells, top of stack in cell 0
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		entry_t above, below;
		if (i == 0) begin : g_top
			assign above = new_entry;
		end else begin : g_mid
			assign above = cells[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign below = cells[i];
		end else begin : g_inner
			assign below = cells[i+1];
		end
		crs_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.from_above (above),
			.from_below (below),
			.entry      (cells[i])
		);
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rnd_q <= '0;
		end else if (s1_adv) begin
			cnt_q <= cnt_nxt;
			rnd_q <= rnd_nxt;
		end
	end

	// Stage 2: carry the request past the stack update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rect_s2 <= rect_s1;
			cnt_s2  <= cnt_nxt;
			rnd_s2  <= rnd_nxt;
			drop_s2 <= dropped;
		end
	end

	crs_check u_check (
		.clip_top        (cells[0].rect),
		.stack_empty     (cnt_s2 == '0),
		.rect            (rect_s2),
		.viewport_height (vh_q),
		.result          (chk)
	);

	assign cnt_ext = {{CntOutW{1'b0}}, cnt_s2};
	assign rnd_ext = {{CntOutW{1'b0}}, rnd_s2};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s2_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_chk_q  <= chk;
			out_cnt_q  <= cnt_ext[CntOutW-1:0];
			out_rnd_q  <= rnd_ext[CntOutW-1:0];
			out_drop_q <= drop_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {27'b0, out_drop_q, out_rnd_q, out_cnt_q,
		out_chk_q.fully_visible, out_chk_q.is_clipped, out_chk_q.scissor_y,
		out_chk_q.clip.h, out_chk_q.clip.w, out_chk_q.clip.y, out_chk_q.clip.x};

	// The stack never holds more than its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntFull)
		else $error("entry count above stack depth");

	// Rounded entries are a subset of all entries
	a_rnd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q <= cnt_q)
		else $error("rounded count above entry count");

	// A dropped push only happens on a full stack
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && drop_s2 |-> cnt_s2 == CntFull)
		else $error("push dropped on a stack that was not full");

	// The stack moves only when a request leaves stage 1
	a_shift_adv: assert property (@(posedge clk) disable iff (!arst_n)
		shift.push || shift.pop |-> s1_adv && !(shift.push && shift.pop))
		else $error("cell shift without an advancing request");

endmodule

`default_nettype wire

// File: hw/rtl/crs_cell.sv
// One cell of the stack chain: holds one entry.
// Takes the entry above on a push, the entry below on a pop. Uses crs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crs_cell
	import crs_pkg::*;
(
	input  wire logic   clk,
	input  wire shift_t shift,
	input  wire entry_t from_above,
	input  wire entry_t from_below,
	output entry_t      entry
);

	entry_t entry_q;

	// Shift down on push, up on pop, otherwise hold
	always_ff @(posedge clk) begin
		if (shift.push) begin
			entry_q <= from_above;
		end else if (shift.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// File: hw/rtl/crs_isect.sv
// Intersection of a pushed rectangle with the current top entry.
// Empty overlap gives the zero rectangle; an empty stack takes the rectangle itself.
// Uses crs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crs_isect
	import crs_pkg::*;
(
	input  wire rect_t  top,
	input  wire logic   stack_empty,
	input  wire rect_t  rect,
	output rect_t       result
);

	logic [20:0] x1, y1;
	logic [21:0] x1_e, y1_e;
	logic [21:0] tx2, ty2, rx2, ry2;
	logic [21:0] x2, y2;
	logic [21:0] w_d, h_d;

	// Near edges: larger origin wins
	always_comb begin
		x1 = ($signed(top.x) > $signed(rect.x)) ? top.x : rect.x;
		y1 = ($signed(top.y) > $signed(rect.y)) ? top.y : rect.y;
		x1_e = {x1[20], x1};
		y1_e = {y1[20], y1};
	end

	// Far edges: smaller end wins
	always_comb begin
		tx2 = {top.x[20], top.x} + {2'b00, top.w};
		ty2 = {top.y[20], top.y} + {2'b00, top.h};
		rx2 = {rect.x[20], rect.x} + {2'b00, rect.w};
		ry2 = {rect.y[20], rect.y} + {2'b00, rect.h};
		x2 = ($signed(tx2) < $signed(rx2)) ? tx2 : rx2;
		y2 = ($signed(ty2) < $signed(ry2)) ? ty2 : ry2;
	end

	// Form the stored rectangle
	always_comb begin
		w_d = x2 - x1_e;
		h_d = y2 - y1_e;
		if (stack_empty) begin
			result = rect;
		end else if ($signed(x2) <= $signed(x1_e) || $signed(y2) <= $signed(y1_e)) begin
			result = '0;
		end else begin
			result.x = x1;
			result.y = y1;
			result.w = w_d[19:0];
			result.h = h_d[19:0];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/crs_check.sv
// Overlap and containment test of a request rectangle against the clip.
// Also flips the clip's bottom edge to a bottom-left-origin scissor Y. Uses crs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crs_check
	import crs_pkg::*;
(
	input  wire rect_t  clip_top,
	input  wire logic   stack_empty,
	input  wire rect_t  rect,
	input  wire logic [15:0] viewport_height,
	output check_t      result
);

	rect_t       clip;
	logic [21:0] cx, cy, cx2, cy2;
	logic [21:0] rx, ry, rx2, ry2;
	logic [22:0] sc_d;
	logic        overlap, contained;

	// Default clip when nothing is stacked
	always_comb begin
		if (stack_empty) begin
			clip.x = '0;
			clip.y = '0;
			clip.w = DefaultExtent;
			clip.h = DefaultExtent;
		end else begin
			clip = clip_top;
		end
	end

	// Edges in common width
	always_comb begin
		cx  = {clip.x[20], clip.x};
		cy  = {clip.y[20], clip.y};
		cx2 = cx + {2'b00, clip.w};
		cy2 = cy + {2'b00, clip.h};
		rx  = {rect.x[20], rect.x};
		ry  = {rect.y[20], rect.y};
		rx2 = rx + {2'b00, rect.w};
		ry2 = ry + {2'b00, rect.h};
	end

	// Strict overlap and full containment
	always_comb begin
		overlap = ($signed(rx) < $signed(cx2)) && ($signed(rx2) > $signed(cx)) &&
			($signed(ry) < $signed(cy2)) && ($signed(ry2) > $signed(cy));
		contained = ($signed(rx) >= $signed(cx)) && ($signed(ry) >= $signed(cy)) &&
			($signed(rx2) <= $signed(cx2)) && ($signed(ry2) <= $signed(cy2));
		sc_d = {7'b0, viewport_height} - {cy2[21], cy2};
	end

	always_comb begin
		result.clip          = clip;
		result.scissor_y     = sc_d[21:0];
		result.is_clipped    = stack_empty ? 1'b0 : !overlap;
		result.fully_visible = stack_empty ? 1'b1 : contained;
	end

endmodule

`default_nettype wire
